[src/lrast_pkg.sv]
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared types and constants of the lazy range-add / range-sum tree.
// ----------------------------------------------------------------------------
`default_nettype none
package lrast_pkg;

  localparam int MaxPositions = 1024;
  localparam int NodeCount    = 4 * MaxPositions;
  localparam int NodeW        = $clog2(NodeCount);
  localparam int PosW         = $clog2(MaxPositions) + 1;
  localparam int StackDepth   = 16;
  localparam int SpW          = $clog2(StackDepth);

  localparam logic ActAdd = 1'b0;
  localparam logic ActSum = 1'b1;

  localparam logic [0:0] RegSizeInUse = 1'b0;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_VISIT, S_VWAIT, S_PDA, S_PDB, S_PDMUL, S_PDW1, S_PDW2,
    S_PDW3, S_DECIDE, S_FMUL, S_FW, S_POP, S_RCA, S_RCB, S_RCC, S_FINISH
  } state_t;

  typedef struct packed {
    logic [63:0] sum;
    logic [63:0] pend;
  } node_t;

  function automatic logic [PosW-1:0] mid_of(input logic [PosW-1:0] l,
                                             input logic [PosW-1:0] r);
    logic [PosW:0] s;
    s = {1'b0, l} + {1'b0, r};
    return s[PosW:1];
  endfunction

  function automatic logic [63:0] mul_len(input logic [63:0] a,
                                          input logic [PosW-1:0] b);
    logic [63+PosW:0] p;
    p = a * b;
    return p[63:0];
  endfunction

endpackage
`default_nettype wire

[src/lrast_ram.sv]
// ----------------------------------------------------------------------------
// lrast_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lrast_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/lrast_cfg.sv]
// ----------------------------------------------------------------------------
// lrast_cfg
// Register bank: holds the size in use and gives the clamped tree span.
// ----------------------------------------------------------------------------
`default_nettype none
module lrast_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [lrast_pkg::PosW-1:0] span
);
  logic [10:0] size_in_use;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= 11'd1024;
    end else if (psel && penable && pwrite && paddr[2] == lrast_pkg::RegSizeInUse) begin
      size_in_use <= pwdata[10:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lrast_pkg::RegSizeInUse) begin
      prdata = {21'd0, size_in_use};
    end
  end

  always_comb begin
    if (size_in_use == 11'd0) begin
      span = lrast_pkg::PosW'(1);
    end else if (32'(size_in_use) > lrast_pkg::MaxPositions) begin
      span = lrast_pkg::PosW'(lrast_pkg::MaxPositions);
    end else begin
      span = lrast_pkg::PosW'(size_in_use);
    end
  end
endmodule
`default_nettype wire

[src/lrast_core.sv]
// ----------------------------------------------------------------------------
// lrast_core
// Tree walker: depth-first traversal with an explicit frame stack, doing
// pending-add push-down and sum updates as read-modify-write on node memory.
// ----------------------------------------------------------------------------
`default_nettype none
module lrast_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [lrast_pkg::PosW-1:0] span,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic [10:0]                in_low,
  input  wire logic [10:0]                in_high,
  input  wire logic signed [31:0]         in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [63:0]                out_sum
);
  localparam int NW = lrast_pkg::NodeW;
  localparam int PW = lrast_pkg::PosW;
  localparam int SW = lrast_pkg::SpW;

  lrast_pkg::state_t state, state_next;

  logic              act;
  logic [10:0]       lo, hi;
  logic [63:0]       v;
  logic [NW-1:0]     cur_k;
  logic [PW-1:0]     cur_l, cur_r;
  logic [63:0]       sk, pk, cl_s, cl_p, cr_s, cr_p, prod_l, prod_r, acc;
  logic [NW-1:0]     clr_cnt;
  logic [SW-1:0]     sp;
  logic [NW-1:0]     stk_k  [lrast_pkg::StackDepth];
  logic [PW-1:0]     stk_l  [lrast_pkg::StackDepth];
  logic [PW-1:0]     stk_r  [lrast_pkg::StackDepth];
  logic              stk_ph [lrast_pkg::StackDepth];

  logic                we;
  logic [NW-1:0]       waddr, raddr;
  lrast_pkg::node_t    wdata, rdata;

  logic [PW-1:0] mid, top_mid, top_l, top_r;
  logic [NW-1:0] kl, kr, top_k;
  logic          top_ph, outside, full;
  logic [SW-1:0] top;

  lrast_ram #(.Width($bits(lrast_pkg::node_t)), .Depth(lrast_pkg::NodeCount)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign mid     = lrast_pkg::mid_of(cur_l, cur_r);
  assign kl      = {cur_k[NW-2:0], 1'b0};
  assign kr      = {cur_k[NW-2:0], 1'b1};
  assign top     = sp - SW'(1);
  assign top_k   = stk_k[top];
  assign top_l   = stk_l[top];
  assign top_r   = stk_r[top];
  assign top_ph  = stk_ph[top];
  assign top_mid = lrast_pkg::mid_of(top_l, top_r);
  assign outside = (PW'(lo) > cur_r) || (PW'(hi) < cur_l);
  assign full    = (PW'(lo) <= cur_l) && (cur_r <= PW'(hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrast_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    we         = 1'b0;
    waddr      = cur_k;
    wdata      = '0;
    raddr      = cur_k;
    unique case (state)
      lrast_pkg::S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        if (clr_cnt == NW'(lrast_pkg::NodeCount - 1)) begin
          state_next = lrast_pkg::S_IDLE;
        end
      end
      lrast_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (in_low <= in_high) ? lrast_pkg::S_VISIT : lrast_pkg::S_FINISH;
        end
      end
      lrast_pkg::S_VISIT: state_next = lrast_pkg::S_VWAIT;
      lrast_pkg::S_VWAIT: begin
        raddr = kl;
        state_next = (cur_l < cur_r && rdata.pend != 64'd0) ? lrast_pkg::S_PDA
                                                             : lrast_pkg::S_DECIDE;
      end
      lrast_pkg::S_PDA: begin
        raddr = kr;
        state_next = lrast_pkg::S_PDB;
      end
      lrast_pkg::S_PDB:   state_next = lrast_pkg::S_PDMUL;
      lrast_pkg::S_PDMUL: state_next = lrast_pkg::S_PDW1;
      lrast_pkg::S_PDW1: begin
        we = 1'b1;
        waddr = kl;
        wdata = '{sum: cl_s + prod_l, pend: cl_p + pk};
        state_next = lrast_pkg::S_PDW2;
      end
      lrast_pkg::S_PDW2: begin
        we = 1'b1;
        waddr = kr;
        wdata = '{sum: cr_s + prod_r, pend: cr_p + pk};
        state_next = lrast_pkg::S_PDW3;
      end
      lrast_pkg::S_PDW3: begin
        we = 1'b1;
        wdata = '{sum: sk, pend: 64'd0};
        state_next = lrast_pkg::S_DECIDE;
      end
      lrast_pkg::S_DECIDE: begin
        if (outside) begin
          state_next = lrast_pkg::S_POP;
        end else if (full) begin
          state_next = (act == lrast_pkg::ActSum) ? lrast_pkg::S_POP : lrast_pkg::S_FMUL;
        end else begin
          state_next = lrast_pkg::S_VISIT;
        end
      end
      lrast_pkg::S_FMUL: state_next = lrast_pkg::S_FW;
      lrast_pkg::S_FW: begin
        we = 1'b1;
        wdata = '{sum: sk + prod_l, pend: (cur_l < cur_r) ? pk + v : pk};
        state_next = lrast_pkg::S_POP;
      end
      lrast_pkg::S_POP: begin
        if (sp == SW'(0)) begin
          state_next = lrast_pkg::S_FINISH;
        end else if (!top_ph) begin
          state_next = lrast_pkg::S_VISIT;
        end else if (act == lrast_pkg::ActAdd) begin
          state_next = lrast_pkg::S_RCA;
        end
      end
      lrast_pkg::S_RCA: begin
        raddr = kl;
        state_next = lrast_pkg::S_RCB;
      end
      lrast_pkg::S_RCB: begin
        raddr = kr;
        state_next = lrast_pkg::S_RCC;
      end
      lrast_pkg::S_RCC: begin
        we = 1'b1;
        wdata = '{sum: cl_s + rdata.sum, pend: 64'd0};
        state_next = lrast_pkg::S_POP;
      end
      lrast_pkg::S_FINISH: begin
        if (act == lrast_pkg::ActAdd || !out_valid || out_ready) begin
          state_next = lrast_pkg::S_IDLE;
        end
      end
      default: state_next = lrast_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == lrast_pkg::S_FINISH && act == lrast_pkg::ActSum &&
          (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        lrast_pkg::S_CLR: clr_cnt <= clr_cnt + NW'(1);
        lrast_pkg::S_IDLE: sp <= '0;
        lrast_pkg::S_DECIDE: begin
          if (!outside && !full) begin
            sp <= sp + SW'(1);
          end
        end
        lrast_pkg::S_POP: begin
          if (sp != SW'(0) && top_ph) begin
            sp <= sp - SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      lrast_pkg::S_IDLE: begin
        act   <= in_action;
        lo    <= in_low;
        hi    <= in_high;
        v     <= 64'(in_value);
        acc   <= '0;
        cur_k <= NW'(1);
        cur_l <= PW'(1);
        cur_r <= span;
      end
      lrast_pkg::S_VWAIT: begin
        sk <= rdata.sum;
        pk <= rdata.pend;
      end
      lrast_pkg::S_PDA: begin
        cl_s <= rdata.sum;
        cl_p <= rdata.pend;
      end
      lrast_pkg::S_PDB: begin
        cr_s <= rdata.sum;
        cr_p <= rdata.pend;
      end
      lrast_pkg::S_PDMUL: begin
        prod_l <= lrast_pkg::mul_len(pk, mid - cur_l + PW'(1));
        prod_r <= lrast_pkg::mul_len(pk, cur_r - mid);
      end
      lrast_pkg::S_PDW3: pk <= '0;
      lrast_pkg::S_DECIDE: begin
        if (!outside && full && act == lrast_pkg::ActSum) begin
          acc <= acc + sk;
        end
        if (!outside && !full) begin
          stk_k[sp]  <= cur_k;
          stk_l[sp]  <= cur_l;
          stk_r[sp]  <= cur_r;
          stk_ph[sp] <= 1'b0;
          cur_k      <= kl;
          cur_r      <= mid;
        end
      end
      lrast_pkg::S_FMUL: prod_l <= lrast_pkg::mul_len(v, cur_r - cur_l + PW'(1));
      lrast_pkg::S_POP: begin
        if (sp != SW'(0)) begin
          if (!top_ph) begin
            stk_ph[top] <= 1'b1;
            cur_k <= {top_k[NW-2:0], 1'b1};
            cur_l <= top_mid + PW'(1);
            cur_r <= top_r;
          end else begin
            cur_k <= top_k;
            cur_l <= top_l;
            cur_r <= top_r;
          end
        end
      end
      lrast_pkg::S_RCB: cl_s <= rdata.sum;
      lrast_pkg::S_FINISH: begin
        if (act == lrast_pkg::ActSum && (!out_valid || out_ready)) begin
          out_sum <= acc;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[src/lazy_range_add_sum_tree_unit.sv]
// ----------------------------------------------------------------------------
// lazy_range_add_sum_tree_unit
// Range-add / range-sum store over positions 1..size_in_use (clamped to 1..1024), held as a lazy
// segment tree in one node memory.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream: tuser carries the action (add or sum),
//   tdata the range bounds and the signed add value. An add gives no
//   transaction on the m_ stream; a sum gives one 64-bit wrapped result.
//   Items are handled one at a time by a walk over the node memory (one
//   read and one write port). Each visited node is read and decided on
//   (VISIT, VWAIT, DECIDE); a pending add is first pushed down to its
//   children (PDA, PDB, PDMUL, PDW1, PDW2, PDW3), and an add that covers it
//   whole updates it (FMUL, FW). A partly covered node is popped twice and,
//   on an add, its sum is rebuilt (RCA, RCB, RCC). Up to about 4*log2(size)
//   nodes are visited; an empty range goes straight to the end of the walk.
//   The result sits in an output register; the next item is accepted while
//   it waits, and the walker only holds at its end if the previous result
//   has still not been taken.
//   After reset a clearing pass zeroes the node memory, during which s_tready
//   stays low; APB writes are taken as ever. size_in_use resets to 1024 and is
//   written at byte address 0 by the user only while the unit is idle; the unit does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module lazy_range_add_sum_tree_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // range_low[10:0], range_high[21:11], add_value[53:22]
  input  wire logic        s_tuser,   // action[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata    // range_sum[63:0]
);
  logic [lrast_pkg::PosW-1:0] span;

  lrast_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .span    (span)
  );

  lrast_core u_core (
    .clk       (clk),
    .rst       (rst),
    .span      (span),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_low    (s_tdata[10:0]),
    .in_high   (s_tdata[21:11]),
    .in_value  (s_tdata[53:22]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sum   (m_tdata)
  );
endmodule
`default_nettype wire

[sim/tree_sum_checker.sv]
// ----------------------------------------------------------------------------
// tree_sum_checker
// Watches the item and result streams and the APB writes of the range-add /
// range-sum tree, keeps its own lazy tree to predict every query sum, and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tree_sum_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [55:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [63:0] m_tdata,
  output int               fail_count,
  output int               sums_pending
);

  logic [63:0] span_total [lrast_pkg::NodeCount];
  logic [63:0] carry_add  [lrast_pkg::NodeCount];
  logic [10:0] positions;
  logic [63:0] sums_due [$];

  function automatic int clamp_size();
    int n;
    n = positions;
    if (n < 1) n = 1;
    if (n > lrast_pkg::MaxPositions) n = lrast_pkg::MaxPositions;
    return n;
  endfunction

  function automatic void hand_down(int k, int l, int r);
    int m;
    logic [63:0] p;
    if (l >= r || carry_add[k] == 64'd0) return;
    m = (l + r) / 2;
    p = carry_add[k];
    span_total[2*k]   += p * 64'(m - l + 1);
    span_total[2*k+1] += p * 64'(r - m);
    carry_add[2*k]    += p;
    carry_add[2*k+1]  += p;
    carry_add[k] = 64'd0;
  endfunction

  function automatic void add_over(int k, int l, int r, int lo, int hi,
                                   logic [63:0] v);
    int m;
    hand_down(k, l, r);
    if (lo > r || hi < l) return;
    if (lo <= l && r <= hi) begin
      span_total[k] += v * 64'(r - l + 1);
      if (l < r) carry_add[k] += v;
      return;
    end
    m = (l + r) / 2;
    add_over(2*k, l, m, lo, hi, v);
    add_over(2*k+1, m + 1, r, lo, hi, v);
    span_total[k] = span_total[2*k] + span_total[2*k+1];
  endfunction

  function automatic logic [63:0] sum_over(int k, int l, int r, int lo, int hi);
    int m;
    hand_down(k, l, r);
    if (lo > r || hi < l) return 64'd0;
    if (lo <= l && r <= hi) return span_total[k];
    m = (l + r) / 2;
    return sum_over(2*k, l, m, lo, hi) + sum_over(2*k+1, m + 1, r, lo, hi);
  endfunction

  always @(posedge clk) begin
    int lo, hi;
    logic [63:0] v, want;
    if (rst) begin
      foreach (span_total[i]) begin
        span_total[i] = 64'd0;
        carry_add[i] = 64'd0;
      end
      positions = 11'd1024;
      sums_due.delete();
      fail_count = 0;
      sums_pending = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == lrast_pkg::RegSizeInUse)
        positions = pwdata[10:0];
      if (s_tvalid && s_tready) begin
        lo = s_tdata[10:0];
        hi = s_tdata[21:11];
        v = {{32{s_tdata[53]}}, s_tdata[53:22]};
        if (s_tuser == lrast_pkg::ActAdd) begin
          if (lo <= hi) add_over(1, 1, clamp_size(), lo, hi, v);
        end else begin
          want = (lo <= hi) ? sum_over(1, 1, clamp_size(), lo, hi) : 64'd0;
          sums_due = {sums_due, want};
        end
      end
      if (m_tvalid && m_tready) begin
        if (sums_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: actual %h", m_tdata);
        end else begin
          want = sums_due.pop_front();
          if (want !== m_tdata) begin
            fail_count++;
            if (fail_count <= 10)
              $display("range_sum mismatch: expected %h actual %h", want, m_tdata);
          end
        end
      end
      sums_pending = sums_due.size();
    end
  end

endmodule
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives range-add and range-sum items through the tree unit under several
// sizes and idling phases, including a long result hold-off; the checker
// predicts and compares, and the verdict is given here.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  int          fail_count, sums_pending;
  int          send_idle = 0, recv_stall = 0;
  bit          hold_off = 1'b0;
  int          quiet = 0;
  int          cur_size = 1024;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lazy_range_add_sum_tree_unit DUT (.*);

  tree_sum_checker checker_i (.*);

  // Watchdog: cycles with no transaction on either stream.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  task automatic write_size(input int n);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {lrast_pkg::RegSizeInUse, 2'b00}; pwdata <= 32'(n);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cur_size = (n < 1) ? 1 : (n > lrast_pkg::MaxPositions ? lrast_pkg::MaxPositions : n);
  endtask

  // Leave tvalid high after the transaction; idling or settle() drops it.
  task automatic send_item(input logic act, input int lo, input int hi,
                           input logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, v, 11'(hi), 11'(lo)};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random();
    int lo, hi, r;
    logic [31:0] v;
    r = $urandom_range(99);
    if (r < 80) begin
      lo = $urandom_range(cur_size, 1);
      hi = $urandom_range(cur_size, lo);
    end else begin
      lo = $urandom_range(2047);
      hi = $urandom_range(2047);
    end
    v = $urandom;
    if ($urandom_range(3) == 0) v = 32'($signed($urandom_range(20)) - 10);
    send_item(1'($urandom_range(1)), lo, hi, v);
  endtask

  // Drain all results and wait until the unit is idle before touching the size.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sums_pending != 0 || !s_tready);
  endtask

  initial begin
    int sizes[6];
    sizes = '{1024, 1, 2, 0, 37, 2047};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, both actions, empty and outside ranges
    send_item(lrast_pkg::ActSum, 1, 1024, 32'd0);
    send_item(lrast_pkg::ActAdd, 1, 1024, 32'h7FFF_FFFF);
    send_item(lrast_pkg::ActAdd, 1024, 1024, 32'h8000_0000);
    send_item(lrast_pkg::ActAdd, 5, 900, 32'hFFFF_FFFF);
    send_item(lrast_pkg::ActAdd, 10, 3, 32'd99);
    send_item(lrast_pkg::ActAdd, 1025, 2047, 32'd7);
    send_item(lrast_pkg::ActAdd, 0, 0, 32'd5);
    send_item(lrast_pkg::ActSum, 1, 1024, 32'hFFFF_FFFF);
    send_item(lrast_pkg::ActSum, 1024, 1024, 32'd0);
    send_item(lrast_pkg::ActSum, 700, 2047, 32'd0);
    send_item(lrast_pkg::ActSum, 9, 2, 32'd0);
    send_item(lrast_pkg::ActSum, 1025, 2047, 32'd0);
    send_item(lrast_pkg::ActSum, 0, 1, 32'd0);
    send_item(lrast_pkg::ActSum, 1, 1, 32'h5555_5555);
    send_item(lrast_pkg::ActSum, 512, 513, 32'hAAAA_AAAA);
    // long hold-off on results so the unit fills up and stalls its input
    hold_off = 1'b1;
    fork
      begin repeat (600) @(posedge clk); hold_off = 1'b0; end
      begin
        for (int i = 0; i < 8; i++) send_item(lrast_pkg::ActSum, 1, 2 + i, 32'd0);
        for (int i = 0; i < 6; i++) send_item(lrast_pkg::ActSum, 3, 1000, 32'd0);
      end
    join
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_size(sizes[ph]);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 53; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 53; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      for (int i = 0; i < 250; i++) send_random();
    end
    settle();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
